// ----- hw/rtl/tmvc_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tmvc_pkg
// Shared widths and Q16.16 fixed-point helpers for the ten-moment conversion.
// -----------------------------------------------------------------------------
package tmvc_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_LANES = 3;
  localparam int NUM_PAIRS = 6;
  // quotient needs WORD_BITS + FRAC_BITS bits before saturation
  localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
  localparam int PROD_BITS = 2 * WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

  // product with magnitude truncation toward zero, then saturation
  function automatic word_t sat_mul(input word_t a, input word_t b);
    logic signed [PROD_BITS-1:0] p;
    logic [PROD_BITS-1:0] mag;
    logic [PROD_BITS-1:0] sh;
    logic neg;
    p = PROD_BITS'(a) * PROD_BITS'(b);
    neg = p[PROD_BITS-1];
    mag = neg ? (~p + 1'b1) : p;
    sh = mag >> FRAC_BITS;
    if (!neg && sh > PROD_BITS'(MAX_W)) return MAX_W;
    if (neg && sh > {{(PROD_BITS-WORD_BITS){1'b0}}, MIN_W}) return MIN_W;
    return neg ? word_t'(~sh + 1'b1) : word_t'(sh);
  endfunction

  // a plus b, or a minus b, saturated
  function automatic word_t sat_addsub(input word_t a, input word_t b, input logic sub);
    logic signed [WORD_BITS:0] s;
    s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
            : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
    if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? MIN_W : MAX_W;
    return s[WORD_BITS-1:0];
  endfunction
endpackage

// ----- hw/rtl/tmvc_div_lane.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tmvc_div_lane
// Pipelined restoring divider: one quotient bit per stage, signed numerator,
// positive divisor, result truncated toward zero and saturated.
// -----------------------------------------------------------------------------
module tmvc_div_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tmvc_pkg::word_t       num,
  input  tmvc_pkg::word_t       den,
  output tmvc_pkg::word_t       quot
);
  localparam int QB = tmvc_pkg::QUOT_BITS;
  localparam int WB = tmvc_pkg::WORD_BITS;

  logic [QB-1:0] nrm [1:QB];
  logic [QB-1:0] qv  [1:QB];
  logic [WB:0]   rem [1:QB];
  logic [WB-1:0] dv  [1:QB];
  logic          ng  [1:QB];

  logic [WB-1:0] mag0;
  logic [QB-1:0] nrm0;
  assign mag0 = num[WB-1] ? (~num + 1'b1) : num;
  assign nrm0 = {mag0, {tmvc_pkg::FRAC_BITS{1'b0}}};

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [QB-1:0] n_cur;
    logic [QB-1:0] q_cur;
    logic [WB:0]   r_cur;
    logic [WB-1:0] d_cur;
    logic          g_cur;
    logic [WB:0]   tr;
    logic          ge;
    if (s == 0) begin : g_head
      assign n_cur = nrm0;
      assign q_cur = '0;
      assign r_cur = '0;
      assign d_cur = den;
      assign g_cur = num[WB-1];
    end else begin : g_body
      assign n_cur = nrm[s];
      assign q_cur = qv[s];
      assign r_cur = rem[s];
      assign d_cur = dv[s];
      assign g_cur = ng[s];
    end
    assign tr = {r_cur[WB-1:0], n_cur[QB-1-s]};
    assign ge = tr >= {1'b0, d_cur};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? tr - {1'b0, d_cur} : tr;
        qv[s+1]  <= {q_cur[QB-2:0], ge};
        nrm[s+1] <= n_cur;
        dv[s+1]  <= d_cur;
        ng[s+1]  <= g_cur;
      end
    end
  end

  logic [QB-1:0] qm;
  assign qm = qv[QB];
  always_comb begin
    if (!ng[QB]) quot = (qm > QB'(tmvc_pkg::MAX_W)) ? tmvc_pkg::MAX_W : WB'(qm);
    else quot = (qm > {{(QB-WB){1'b0}}, tmvc_pkg::MIN_W}) ? tmvc_pkg::MIN_W
                                                        : WB'(~qm + 1'b1);
  end

  logic unused_rst;
  assign unused_rst = rst;
endmodule

// ----- hw/rtl/tmvc_merge.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tmvc_merge
// Combines lane results: momentum products, then the six tensor updates.
// -----------------------------------------------------------------------------
module tmvc_merge (
  input  logic            clk,
  input  logic            en,
  input  logic            to_prim,
  input  tmvc_pkg::word_t r,
  input  tmvc_pkg::word_t a [tmvc_pkg::NUM_LANES],
  input  tmvc_pkg::word_t t [tmvc_pkg::NUM_PAIRS],
  output tmvc_pkg::word_t vel_out [tmvc_pkg::NUM_LANES],
  output tmvc_pkg::word_t ten_out [tmvc_pkg::NUM_PAIRS]
);
  localparam int PI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PJ [6] = '{0, 1, 2, 1, 2, 2};

  tmvc_pkg::word_t ra [tmvc_pkg::NUM_LANES];
  tmvc_pkg::word_t a1 [tmvc_pkg::NUM_LANES];
  tmvc_pkg::word_t t1 [tmvc_pkg::NUM_PAIRS];
  tmvc_pkg::word_t term [tmvc_pkg::NUM_PAIRS];
  tmvc_pkg::word_t t2 [tmvc_pkg::NUM_PAIRS];
  logic p1, p2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < tmvc_pkg::NUM_LANES; k++) begin
        ra[k] <= tmvc_pkg::sat_mul(r, a[k]);
        a1[k] <= a[k];
      end
      t1 <= t;
      p1 <= to_prim;
      for (int k = 0; k < tmvc_pkg::NUM_PAIRS; k++)
        term[k] <= tmvc_pkg::sat_mul(ra[PI[k]], a1[PJ[k]]);
      t2 <= t1;
      p2 <= p1;
      for (int k = 0; k < tmvc_pkg::NUM_LANES; k++)
        vel_out[k] <= p1 ? a1[k] : ra[k];
    end
  end

  always_comb begin
    for (int k = 0; k < tmvc_pkg::NUM_PAIRS; k++)
      ten_out[k] = tmvc_pkg::sat_addsub(t2[k], term[k], p2);
  end
endmodule

// ----- hw/rtl/ten_moment_variable_conversion_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ten_moment_variable_conversion_top
// Conservative/primitive conversion of ten fluid moments in Q16.16.
// -----------------------------------------------------------------------------
// One transaction per grid cell on the input channel (valid/stall), one
// result transaction per cell on the output channel, in order.
// The datapath is a stall-together pipeline: three divider lanes (one per
// velocity component, one quotient bit per stage, 48 stages) feed a merge
// block of three momentum and six tensor multipliers.
// Throughput: one cell per cycle while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline holds; the input
// stall rises only while the output register is full and stalled, so no data
// is lost. Reset clears all valid bits; no other register is reset.
// Mode 1 passes through the divider pipeline unused, keeping order.
// -----------------------------------------------------------------------------
module ten_moment_variable_conversion_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic signed [31:0]     density,
  input  logic signed [31:0]     x_term,
  input  logic signed [31:0]     y_term,
  input  logic signed [31:0]     z_term,
  input  logic signed [31:0]     tensor_xx,
  input  logic signed [31:0]     tensor_xy,
  input  logic signed [31:0]     tensor_xz,
  input  logic signed [31:0]     tensor_yy,
  input  logic signed [31:0]     tensor_yz,
  input  logic signed [31:0]     tensor_zz,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     density_out,
  output logic signed [31:0]     x_out,
  output logic signed [31:0]     y_out,
  output logic signed [31:0]     z_out,
  output logic signed [31:0]     xx_out,
  output logic signed [31:0]     xy_out,
  output logic signed [31:0]     xz_out,
  output logic signed [31:0]     yy_out,
  output logic signed [31:0]     yz_out,
  output logic signed [31:0]     zz_out,
  output logic                   bad_density
);
  localparam int DL = tmvc_pkg::QUOT_BITS;
  localparam int LAT = DL + 2;

  logic en;
  logic [LAT-1:0] vld;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  tmvc_pkg::word_t mom [3];
  tmvc_pkg::word_t quo [3];
  assign mom[0] = x_term;
  assign mom[1] = y_term;
  assign mom[2] = z_term;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    tmvc_div_lane u_div (
      .clk(clk), .rst(rst), .en(en),
      .num(mom[l]), .den(density), .quot(quo[l])
    );
  end

  // side data delayed along with the divider
  logic            md [1:DL];
  tmvc_pkg::word_t rd [1:DL];
  tmvc_pkg::word_t vd [1:DL][3];
  tmvc_pkg::word_t td [1:DL][6];
  always_ff @(posedge clk) begin
    if (en) begin
      md[1] <= mode; rd[1] <= density;
      vd[1][0] <= x_term; vd[1][1] <= y_term; vd[1][2] <= z_term;
      td[1][0] <= tensor_xx; td[1][1] <= tensor_xy; td[1][2] <= tensor_xz;
      td[1][3] <= tensor_yy; td[1][4] <= tensor_yz; td[1][5] <= tensor_zz;
      for (int s = 1; s < DL; s++) begin
        md[s+1] <= md[s]; rd[s+1] <= rd[s];
        vd[s+1] <= vd[s]; td[s+1] <= td[s];
      end
    end
  end

  logic to_prim, bad;
  tmvc_pkg::word_t a [3];
  assign to_prim = !md[DL];
  assign bad = to_prim && (rd[DL][31] || rd[DL] == '0);
  always_comb begin
    for (int k = 0; k < 3; k++)
      a[k] = to_prim ? (bad ? '0 : quo[k]) : vd[DL][k];
  end

  tmvc_pkg::word_t vel [3];
  tmvc_pkg::word_t ten [6];
  tmvc_merge u_merge (
    .clk(clk), .en(en), .to_prim(to_prim), .r(rd[DL]), .a(a), .t(td[DL]),
    .vel_out(vel), .ten_out(ten)
  );

  logic [1:0] bd;
  tmvc_pkg::word_t r1, r2;
  always_ff @(posedge clk) begin
    if (en) begin
      bd <= {bd[0], bad};
      r1 <= rd[DL];
      r2 <= r1;
    end
  end

  assign density_out = r2;
  assign x_out = vel[0];
  assign y_out = vel[1];
  assign z_out = vel[2];
  assign xx_out = ten[0];
  assign xy_out = ten[1];
  assign xz_out = ten[2];
  assign yy_out = ten[3];
  assign yz_out = ten[4];
  assign zz_out = ten[5];
  assign bad_density = bd[1];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(x_out))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_density |-> x_out == '0 && y_out == '0 && z_out == '0)
    else $error("bad density with nonzero velocity");
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ten-moment conservative/primitive conversion.
// A Q16.16 predictor computes each expected cell. A checker compares every
// result as a whole, while sender and receiver idle and stall at random.
// -----------------------------------------------------------------------------
module tb_top;
  typedef struct packed {
    logic        mode;
    logic [31:0] rho, px, py, pz, txx, txy, txz, tyy, tyz, tzz;
  } cell_t;

  typedef struct packed {
    logic [31:0] rho, vx, vy, vz, oxx, oxy, oxz, oyy, oyz, ozz;
    logic        bad;
  } conv_t;

  localparam longint MAX_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, mode = 0;
  logic signed [31:0] density = 0, x_term = 0, y_term = 0, z_term = 0;
  logic signed [31:0] tensor_xx = 0, tensor_xy = 0, tensor_xz = 0;
  logic signed [31:0] tensor_yy = 0, tensor_yz = 0, tensor_zz = 0;
  logic in_stall, out_valid, bad_density;
  logic signed [31:0] density_out, x_out, y_out, z_out;
  logic signed [31:0] xx_out, xy_out, xz_out, yy_out, yz_out, zz_out;

  conv_t expected_cells[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  longint cycle_count = 0;

  ten_moment_variable_conversion_top dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- predictor: long arithmetic then clamp
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p, m;
    p = a * b;  // fits: |a|,|b| <= 2^31
    m = (p < 0 ? -p : p) >>> 16;
    return clamp32(p < 0 ? -m : m);
  endfunction

  function automatic longint qdiv(longint a, longint r);
    longint m, q;
    m = a < 0 ? -a : a;
    q = (m << 16) / r;
    return clamp32(a < 0 ? -q : q);
  endfunction

  function automatic conv_t convert_cell(cell_t c);
    conv_t o;
    longint r, v[3], rv[3], t[6], term, res[6];
    int pi[6] = '{0, 0, 0, 1, 1, 2};
    int pj[6] = '{0, 1, 2, 1, 2, 2};
    bit to_prim, bad;
    r = longint'($signed(c.rho));
    v[0] = longint'($signed(c.px));
    v[1] = longint'($signed(c.py));
    v[2] = longint'($signed(c.pz));
    t[0] = longint'($signed(c.txx)); t[1] = longint'($signed(c.txy));
    t[2] = longint'($signed(c.txz)); t[3] = longint'($signed(c.tyy));
    t[4] = longint'($signed(c.tyz)); t[5] = longint'($signed(c.tzz));
    to_prim = !c.mode;
    bad = to_prim && r <= 0;
    if (to_prim)
      for (int k = 0; k < 3; k++) v[k] = bad ? 0 : qdiv(v[k], r);
    for (int k = 0; k < 3; k++) rv[k] = qmul(r, v[k]);
    for (int k = 0; k < 6; k++) begin
      term = qmul(rv[pi[k]], v[pj[k]]);
      res[k] = clamp32(to_prim ? t[k] - term : t[k] + term);
    end
    o.rho = c.rho;
    o.vx = to_prim ? v[0][31:0] : rv[0][31:0];
    o.vy = to_prim ? v[1][31:0] : rv[1][31:0];
    o.vz = to_prim ? v[2][31:0] : rv[2][31:0];
    o.oxx = res[0][31:0]; o.oxy = res[1][31:0]; o.oxz = res[2][31:0];
    o.oyy = res[3][31:0]; o.oyz = res[4][31:0]; o.ozz = res[5][31:0];
    o.bad = bad;
    return o;
  endfunction

  // ---- sender
  task automatic send_cell(cell_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    mode <= c.mode;
    density <= c.rho; x_term <= c.px; y_term <= c.py; z_term <= c.pz;
    tensor_xx <= c.txx; tensor_xy <= c.txy; tensor_xz <= c.txz;
    tensor_yy <= c.tyy; tensor_yz <= c.tyz; tensor_zz <= c.tzz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_cells.push_back(convert_cell(c));
    @(negedge clk);
  endtask

  // ---- receiver stall
  always @(negedge clk)
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

  // ---- result checker
  always @(posedge clk) begin
    conv_t e, a;
    if (!rst && out_valid && !out_stall) begin
      a = '{density_out, x_out, y_out, z_out, xx_out, xy_out, xz_out,
            yy_out, yz_out, zz_out, bad_density};
      if (expected_cells.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
      end else begin
        e = expected_cells.pop_front();
        if (e !== a) begin
          errors++;
          $display("%0t: mismatch expected %h actual %h", $time, e, a);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      3: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c = '0;
    c.mode = 1'($urandom_range(1));
    case ($urandom_range(4))
      0: c.rho = rand_word();
      1: c.rho = $urandom_range(3) == 0 ? 32'h0 : 32'h0001_0000;
      default: c.rho = $urandom_range(32'h0010_0000, 1);
    endcase
    c.px = rand_word(); c.py = rand_word(); c.pz = rand_word();
    c.txx = rand_word(); c.tyy = rand_word(); c.tzz = rand_word();
    c.txy = rand_word(); c.txz = rand_word(); c.tyz = rand_word();
    return c;
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    @(negedge clk);
    while (expected_cells.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] w[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000,
                          32'hffff_0000, 32'h0000_0001};
    for (int m = 0; m < 2; m++)
      for (int i = 0; i < 6; i++)
        send_cell('{m[0], w[i], w[(i+1)%6], w[(i+2)%6], w[(i+3)%6],
                    w[i], w[(i+4)%6], w[(i+5)%6], w[(i+1)%6], w[i], w[(i+2)%6]});
    // tiny density drives the x and y quotients into saturation
    send_cell('{1'b0, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h0, 32'h0,
                32'h0, 32'h0, 32'h0, 32'h0});
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_cell(rand_cell());
  endtask

  // receiver holds off long enough for the pipeline to back up
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      test_random(80);
    join
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    send_idle_pct = 29; recv_idle_pct = 53;
    test_random(320);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    send_idle_pct = 53; recv_idle_pct = 29;
    test_random(320);
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(320);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
